[design/qte_pkg.sv]
// Shared constants, tables and types for the quaternion to Euler angle core.
package qte_pkg;

	localparam int QTE_DATA_WIDTH    = 16;
	localparam int QTE_CORDIC_STAGES = 16;

	// CORDIC angle accumulator: pi is 2^31
	localparam int ACC_ZW = 34;
	localparam logic signed [ACC_ZW-1:0] ACC_PI = ACC_ZW'(64'sd2147483648);

	// square root unit for the pitch cosine term
	localparam int SQ_BITS = 31;
	localparam int SQ_RAD  = 2 * SQ_BITS;
	localparam int SQ_REM  = SQ_BITS + 2;
	localparam logic [SQ_BITS-1:0] SQ_ONE = SQ_BITS'(1) << 30;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	typedef struct packed {
		logic               sat_pos;
		logic               sat_neg;
		logic               s_neg;
		logic [SQ_BITS-1:0] m30;
	} pitch_side_t;

	typedef struct packed {
		logic sat_pos;
		logic sat_neg;
	} pitch_sat_t;

endpackage

[design/qte_isqrt_cell.sv]
// One bit-pair step of the pipelined integer square root.
module qte_isqrt_cell
	import qte_pkg::*;
(
	input  logic               clk,
	input  logic [SQ_RAD-1:0]  v_i,
	input  logic [SQ_REM-1:0]  rem_i,
	input  logic [SQ_BITS-1:0] root_i,
	output logic [SQ_RAD-1:0]  v_o,
	output logic [SQ_REM-1:0]  rem_o,
	output logic [SQ_BITS-1:0] root_o
);

	logic [SQ_REM+1:0] rem2;
	logic [SQ_REM+1:0] trial;

	assign rem2  = {rem_i, v_i[SQ_RAD-1 -: 2]};
	assign trial = (SQ_REM+2)'({root_i, 2'b01});

	always_ff @(posedge clk) begin
		v_o <= v_i << 2;
		if (rem2 >= trial) begin
			rem_o  <= SQ_REM'(rem2 - trial);
			root_o <= {root_i[SQ_BITS-2:0], 1'b1};
		end else begin
			rem_o  <= SQ_REM'(rem2);
			root_o <= {root_i[SQ_BITS-2:0], 1'b0};
		end
	end

endmodule

[design/qte_cordic_cell.sv]
// One vectoring-mode CORDIC rotation with its fixed shift and angle.
module qte_cordic_cell
	import qte_pkg::*;
#(
	parameter int          W     = 36,
	parameter int          SHIFT = 0,
	parameter logic [31:0] ANGLE = 32'h0
) (
	input  logic                     clk,
	input  logic signed [W-1:0]      x_i,
	input  logic signed [W-1:0]      y_i,
	input  logic signed [ACC_ZW-1:0] z_i,
	output logic signed [W-1:0]      x_o,
	output logic signed [W-1:0]      y_o,
	output logic signed [ACC_ZW-1:0] z_o
);

	localparam logic signed [ACC_ZW-1:0] ANG = ACC_ZW'(ANGLE);

	logic signed [W-1:0] sx;
	logic signed [W-1:0] sy;

	assign sx = x_i >>> SHIFT;
	assign sy = y_i >>> SHIFT;

	always_ff @(posedge clk) begin
		if (!y_i[W-1]) begin
			x_o <= x_i + sy;
			y_o <= y_i - sx;
			z_o <= z_i + ANG;
		end else begin
			x_o <= x_i - sy;
			y_o <= y_i + sx;
			z_o <= z_i - ANG;
		end
	end

endmodule

[design/qte_cordic.sv]
// Pipelined four-quadrant arctangent: pre-rotation, a row of CORDIC cells, rounding.
module qte_cordic
	import qte_pkg::*;
#(
	parameter int DW     = QTE_DATA_WIDTH,
	parameter int STAGES = QTE_CORDIC_STAGES,
	parameter int W      = 36
) (
	input  logic                clk,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	output logic [DW-1:0]       angle
);

	localparam int NS = (STAGES > 32) ? 32 : STAGES;
	localparam int SH = 32 - DW;

	logic signed [W-1:0]      cx [NS+1];
	logic signed [W-1:0]      cy [NS+1];
	logic signed [ACC_ZW-1:0] cz [NS+1];
	logic                     zf_q [NS+1];
	logic [DW-1:0]            angle_q;
	logic [DW-1:0]            rnd;

	// fold the left half-plane onto the right one
	always_ff @(posedge clk) begin
		zf_q[0] <= (x_in == '0) && (y_in == '0);
		if (x_in[W-1]) begin
			cx[0] <= -x_in;
			cy[0] <= -y_in;
			cz[0] <= y_in[W-1] ? -ACC_PI : ACC_PI;
		end else begin
			cx[0] <= x_in;
			cy[0] <= y_in;
			cz[0] <= '0;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_cell
		qte_cordic_cell #(
			.W     (W),
			.SHIFT (k),
			.ANGLE (ATAN_TAB[k])
		) u_cell (
			.clk (clk),
			.x_i (cx[k]),
			.y_i (cy[k]),
			.z_i (cz[k]),
			.x_o (cx[k+1]),
			.y_o (cy[k+1]),
			.z_o (cz[k+1])
		);
		always_ff @(posedge clk) begin
			zf_q[k+1] <= zf_q[k];
		end
	end

	if (SH > 0) begin : g_rnd
		logic signed [ACC_ZW-1:0] zr;
		assign zr  = (cz[NS] + (ACC_ZW'(1) <<< (SH - 1))) >>> SH;
		assign rnd = DW'(zr);
	end else begin : g_nornd
		assign rnd = DW'(cz[NS]);
	end

	always_ff @(posedge clk) begin
		angle_q <= zf_q[NS] ? '0 : rnd;
	end

	assign angle = angle_q;

endmodule

[design/quaternion_to_euler_core.sv]
// Quaternion to ZYX Euler angles core (top level).
// Usage: drive quat_w/x/y/z (signed Q1.(DATA_WIDTH-2)) and pulse start; a word
// is taken at every rising edge with start high and busy low. busy stays low,
// so a new quaternion may enter on every cycle.
// Results: done is high for one cycle with roll_angle, pitch_angle and
// yaw_angle (binary angle units, 2^(DATA_WIDTH-1) is pi). The receiver cannot
// hold a word off; it must take it in that cycle.
// Throughput: one word per cycle. The latency is set by the pitch path: two
// product stages, pitch prep, the 31x31 multiply, 31 square root cells, then
// the CORDIC pre-stage, CORDIC_STAGES cells and the rounding register. Roll
// and yaw run through their own CORDIC rows and are delayed to line up.
// Reset clears the valid chain; words in flight are dropped and no done
// pulse follows until new words are taken.
module quaternion_to_euler_core
	import qte_pkg::*;
#(
	parameter int DATA_WIDTH    = QTE_DATA_WIDTH,
	parameter int CORDIC_STAGES = QTE_CORDIC_STAGES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] quat_w,
	input  logic signed [DATA_WIDTH-1:0] quat_x,
	input  logic signed [DATA_WIDTH-1:0] quat_y,
	input  logic signed [DATA_WIDTH-1:0] quat_z,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] roll_angle,
	output logic signed [DATA_WIDTH-1:0] pitch_angle,
	output logic signed [DATA_WIDTH-1:0] yaw_angle
);

	localparam int DW     = DATA_WIDTH;
	localparam int F2     = 2 * (DW - 2);
	localparam int PW     = 2 * DW;
	localparam int TW     = 2 * DW + 3;
	localparam int CW     = (2 * DW + 4 > 34) ? 2 * DW + 4 : 34;
	localparam int NS     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int SQ_SHL = (F2 <= 30) ? 30 - F2 : 0;
	localparam int SQ_SHR = (F2 > 30) ? F2 - 30 : 0;
	localparam int RY_DLY = 33;
	localparam int FL_DLY = NS + 2;
	localparam int LAT    = 37 + NS;

	localparam logic signed [TW-1:0] ONE2    = TW'(1) <<< F2;
	localparam logic signed [DW-1:0] HALF_PI = DW'(1) <<< (DW - 2);

	// products
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	// terms
	logic signed [TW-1:0] sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;

	logic [TW-1:0]        mag_u;
	logic [TW+SQ_SHL-1:0] mag_w;
	pitch_side_t          side_s3;
	logic [SQ_BITS-1:0]   sa, sb;
	logic [SQ_RAD-1:0]    prod_s4;

	logic [SQ_RAD-1:0]    sq_v    [SQ_BITS+1];
	logic [SQ_REM-1:0]    sq_rem  [SQ_BITS+1];
	logic [SQ_BITS-1:0]   sq_root [SQ_BITS+1];
	pitch_side_t          side_q  [SQ_BITS+1];
	pitch_sat_t           fl_q    [FL_DLY];

	logic signed [CW-1:0] px, py;
	logic [DW-1:0]        roll_c, yaw_c, pitch_c;
	logic [DW-1:0]        roll_q [RY_DLY];
	logic [DW-1:0]        yaw_q  [RY_DLY];
	logic [LAT-1:0]       vld_q;

	assign busy = 1'b0;

	always_ff @(posedge clk) begin
		wx_s1 <= PW'(quat_w) * PW'(quat_x);
		yz_s1 <= PW'(quat_y) * PW'(quat_z);
		xx_s1 <= PW'(quat_x) * PW'(quat_x);
		yy_s1 <= PW'(quat_y) * PW'(quat_y);
		wy_s1 <= PW'(quat_w) * PW'(quat_y);
		zx_s1 <= PW'(quat_z) * PW'(quat_x);
		wz_s1 <= PW'(quat_w) * PW'(quat_z);
		xy_s1 <= PW'(quat_x) * PW'(quat_y);
		zz_s1 <= PW'(quat_z) * PW'(quat_z);
	end

	always_ff @(posedge clk) begin
		sr_s2 <= (TW'(wx_s1) + TW'(yz_s1)) <<< 1;
		cr_s2 <= ONE2 - ((TW'(xx_s1) + TW'(yy_s1)) <<< 1);
		sp_s2 <= (TW'(wy_s1) - TW'(zx_s1)) <<< 1;
		sy_s2 <= (TW'(wz_s1) + TW'(xy_s1)) <<< 1;
		cy_s2 <= ONE2 - ((TW'(yy_s1) + TW'(zz_s1)) <<< 1);
	end

	// pitch prep: saturation, magnitude rescaled to Q.30
	assign mag_u = sp_s2[TW-1] ? TW'(-sp_s2) : TW'(sp_s2);
	assign mag_w = (TW + SQ_SHL)'(mag_u) << SQ_SHL;

	always_ff @(posedge clk) begin
		side_s3.sat_pos <= sp_s2 >= ONE2;
		side_s3.sat_neg <= sp_s2 <= -ONE2;
		side_s3.s_neg   <= sp_s2[TW-1];
		side_s3.m30     <= SQ_BITS'(mag_w >> SQ_SHR);
	end

	assign sa = SQ_ONE - side_s3.m30;
	assign sb = SQ_ONE + side_s3.m30;

	always_ff @(posedge clk) begin
		prod_s4   <= SQ_RAD'(sa) * SQ_RAD'(sb);
		side_q[0] <= side_s3;
	end

	// cosine term: floor(sqrt(prod)), one root bit per cell
	assign sq_v[0]    = prod_s4;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQ_BITS; k++) begin : g_sq
		qte_isqrt_cell u_sq (
			.clk    (clk),
			.v_i    (sq_v[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.v_o    (sq_v[k+1]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1])
		);
		always_ff @(posedge clk) begin
			side_q[k+1] <= side_q[k];
		end
	end

	assign py = side_q[SQ_BITS].s_neg ? -CW'(side_q[SQ_BITS].m30) : CW'(side_q[SQ_BITS].m30);
	assign px = CW'(sq_root[SQ_BITS]);

	always_ff @(posedge clk) begin
		fl_q[0] <= '{sat_pos: side_q[SQ_BITS].sat_pos, sat_neg: side_q[SQ_BITS].sat_neg};
	end
	for (genvar k = 1; k < FL_DLY; k++) begin : g_fl
		always_ff @(posedge clk) begin
			fl_q[k] <= fl_q[k-1];
		end
	end

	qte_cordic #(.DW(DW), .STAGES(CORDIC_STAGES), .W(CW)) u_roll (
		.clk   (clk),
		.x_in  (CW'(cr_s2)),
		.y_in  (CW'(sr_s2)),
		.angle (roll_c)
	);

	qte_cordic #(.DW(DW), .STAGES(CORDIC_STAGES), .W(CW)) u_yaw (
		.clk   (clk),
		.x_in  (CW'(cy_s2)),
		.y_in  (CW'(sy_s2)),
		.angle (yaw_c)
	);

	qte_cordic #(.DW(DW), .STAGES(CORDIC_STAGES), .W(CW)) u_pitch (
		.clk   (clk),
		.x_in  (px),
		.y_in  (py),
		.angle (pitch_c)
	);

	// hold roll and yaw until pitch catches up
	always_ff @(posedge clk) begin
		roll_q[0] <= roll_c;
		yaw_q[0]  <= yaw_c;
	end
	for (genvar k = 1; k < RY_DLY; k++) begin : g_ry
		always_ff @(posedge clk) begin
			roll_q[k] <= roll_q[k-1];
			yaw_q[k]  <= yaw_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done        = vld_q[LAT-1];
	assign roll_angle  = roll_q[RY_DLY-1];
	assign yaw_angle   = yaw_q[RY_DLY-1];
	assign pitch_angle = fl_q[FL_DLY-1].sat_pos ? HALF_PI :
	                     fl_q[FL_DLY-1].sat_neg ? -HALF_PI : pitch_c;

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted word produced no result");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(start, LAT))
		else $error("result without matching accepted word");

	a_sat_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(fl_q[FL_DLY-1].sat_pos && fl_q[FL_DLY-1].sat_neg))
		else $error("pitch saturated both ways");

endmodule

[tb/tb_quaternion_to_euler_core.sv]
// Self-checking testbench for the quaternion to Euler angle core.
module tb_quaternion_to_euler_core;
	import qte_pkg::*;

	localparam int DW        = QTE_DATA_WIDTH;
	localparam int FB        = DW - 2;
	localparam int LATENCY   = 37 + QTE_CORDIC_STAGES;
	localparam int WDOG_MAX  = 20 * LATENCY + 2000;
	localparam int HOLD_AT   = 700;

	typedef struct {
		logic signed [DW-1:0] w, x, y, z;
	} quat_t;

	typedef struct {
		logic signed [DW-1:0] roll, pitch, yaw;
	} euler_t;

	logic clk, arst_n, start, busy, done;
	logic signed [DW-1:0] quat_w, quat_x, quat_y, quat_z;
	logic signed [DW-1:0] roll_angle, pitch_angle, yaw_angle;

	quat_t  quat_pending[$];
	euler_t euler_expected[$];
	quat_t  word_on_bus;
	int     words_taken;
	int     errors;
	int     idle_cycles;

	quaternion_to_euler_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// vectoring CORDIC, accumulator holds pi as 2^31
	function automatic longint cordic_angle(longint vy, longint vx);
		longint acc;
		longint dx, dy;
		acc = 0;
		if (vx == 0 && vy == 0)
			return 0;
		if (vx < 0) begin
			acc = (vy >= 0) ? 64'sd2147483648 : -64'sd2147483648;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < QTE_CORDIC_STAGES && i < 32; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx;
				vy -= dy;
				acc += longint'(ATAN_TAB[i]);
			end else begin
				vx -= dx;
				vy += dy;
				acc -= longint'(ATAN_TAB[i]);
			end
		end
		return acc;
	endfunction

	function automatic logic [DW-1:0] round_angle(longint acc);
		longint r;
		r = (acc + (longint'(1) << (31 - DW))) >>> (32 - DW);
		return r[DW-1:0];
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic [DW-1:0] pitch_from_sine(longint s);
		longint one2, mag, m30, c;
		one2 = longint'(1) << (2 * FB);
		if (s >= one2)
			return DW'(1 << (DW - 2));
		if (s <= -one2)
			return DW'(-(1 << (DW - 2)));
		mag = (s < 0) ? -s : s;
		m30 = (2 * FB <= 30) ? (mag << (30 - 2 * FB)) : (mag >> (2 * FB - 30));
		c = int_sqrt(longint'((longint'(1) << 30) - m30) * ((longint'(1) << 30) + m30));
		return round_angle(cordic_angle((s < 0) ? -m30 : m30, c));
	endfunction

	function automatic euler_t quat_to_euler(quat_t q);
		longint w, x, y, z, one2;
		euler_t e;
		w = q.w;
		x = q.x;
		y = q.y;
		z = q.z;
		one2 = longint'(1) << (2 * FB);
		e.roll  = round_angle(cordic_angle(2 * (w * x + y * z), one2 - 2 * (x * x + y * y)));
		e.pitch = pitch_from_sine(2 * (w * y - z * x));
		e.yaw   = round_angle(cordic_angle(2 * (w * z + x * y), one2 - 2 * (y * y + z * z)));
		return e;
	endfunction

	function automatic quat_t mk_quat(int w, int x, int y, int z);
		quat_t q;
		q.w = DW'(w);
		q.x = DW'(x);
		q.y = DW'(y);
		q.z = DW'(z);
		return q;
	endfunction

	function automatic int rand_comp();
		return int'($urandom_range(32768)) - 16384;
	endfunction

	// random direction scaled to unit length
	function automatic quat_t rand_unit_quat();
		real a, b, c, d, n;
		a = real'(rand_comp());
		b = real'(rand_comp());
		c = real'(rand_comp());
		d = real'(rand_comp());
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0)
			return mk_quat(16384, 0, 0, 0);
		n = 16384.0 / n;
		return mk_quat(int'(a * n), int'(b * n), int'(c * n), int'(d * n));
	endfunction

	function automatic bit sender_idles(int taken);
		int pct;
		if (taken < 350)
			pct = 0;
		else if (taken < 700)
			pct = 49;
		else if (taken < 1050)
			pct = 0;
		else
			pct = 13;
		return $urandom_range(99) < pct;
	endfunction

	// driver: take the accepted word, then present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			quat_w <= '0;
			quat_x <= '0;
			quat_y <= '0;
			quat_z <= '0;
			words_taken <= 0;
		end else begin
			automatic bit took = start && !busy;
			automatic bit hold;
			if (took) begin
				euler_expected.push_back(quat_to_euler(word_on_bus));
				words_taken <= words_taken + 1;
			end
			if (start && !took) begin
				// keep the word steady until accepted
			end else begin
				hold = sender_idles(words_taken)
					|| (words_taken + took == HOLD_AT && (euler_expected.size() != 0));
				if (quat_pending.size() != 0 && !hold) begin
					word_on_bus = quat_pending.pop_front();
					start <= 1'b1;
					quat_w <= word_on_bus.w;
					quat_x <= word_on_bus.x;
					quat_y <= word_on_bus.y;
					quat_z <= word_on_bus.z;
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (euler_expected.size() == 0) begin
				$display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d",
					$time, roll_angle, pitch_angle, yaw_angle);
				errors++;
			end else begin
				automatic euler_t e = euler_expected.pop_front();
				if (roll_angle !== e.roll) begin
					$display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_angle);
					errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_angle);
					errors++;
				end
				if (yaw_angle !== e.yaw) begin
					$display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw_angle);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word or result
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int kind;
		errors = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		// directed: zero, identities, axes, extremes, gimbal lock, roll at pi
		quat_pending.push_back(mk_quat(0, 0, 0, 0));
		quat_pending.push_back(mk_quat(16384, 0, 0, 0));
		quat_pending.push_back(mk_quat(-16384, 0, 0, 0));
		quat_pending.push_back(mk_quat(0, 16384, 0, 0));
		quat_pending.push_back(mk_quat(0, 0, 16384, 0));
		quat_pending.push_back(mk_quat(0, 0, 0, 16384));
		quat_pending.push_back(mk_quat(0, -16384, 0, 0));
		quat_pending.push_back(mk_quat(0, 0, -16384, 0));
		quat_pending.push_back(mk_quat(0, 0, 0, -16384));
		quat_pending.push_back(mk_quat(16384, 16384, 16384, 16384));
		quat_pending.push_back(mk_quat(-16384, -16384, -16384, -16384));
		quat_pending.push_back(mk_quat(16384, -16384, 16384, -16384));
		quat_pending.push_back(mk_quat(11585, 0, 11585, 0));
		quat_pending.push_back(mk_quat(11585, 0, -11585, 0));
		quat_pending.push_back(mk_quat(11586, 0, 11586, 0));
		quat_pending.push_back(mk_quat(11586, 0, -11586, 0));
		quat_pending.push_back(mk_quat(0, 11586, 0, -11586));
		quat_pending.push_back(mk_quat(16384, 0, 16384, 0));
		quat_pending.push_back(mk_quat(16384, 0, -16384, 0));
		quat_pending.push_back(mk_quat(11585, 11585, 0, 0));
		quat_pending.push_back(mk_quat(1, 0, 0, 0));
		quat_pending.push_back(mk_quat(-1, -1, -1, -1));
		quat_pending.push_back(mk_quat(0, 1, 1, 1));
		for (int i = 0; i < 1380; i++) begin
			kind = $urandom_range(9);
			if (kind < 6)
				quat_pending.push_back(rand_unit_quat());
			else if (kind < 9)
				quat_pending.push_back(mk_quat(rand_comp(), rand_comp(),
					rand_comp(), rand_comp()));
			else
				quat_pending.push_back(mk_quat(
					$urandom_range(1) ? 16384 : -16384, $urandom_range(2) * 16384 - 16384,
					$urandom_range(2) * 16384 - 16384, $urandom_range(2) * 16384 - 16384));
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (quat_pending.size() != 0 || start || euler_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
design/qte_pkg.sv
design/qte_isqrt_cell.sv
design/qte_cordic_cell.sv
design/qte_cordic.sv
design/quaternion_to_euler_core.sv
tb/tb_quaternion_to_euler_core.sv
